// ===== rtl/stg_pkg.sv =====
// Shared constants, types and the quarter-wave sine table for the sine tone generator.
// No dependencies; stg_fill, the top level, the checker and the testbench import this package.
`default_nettype none

package stg_pkg;

    localparam int PHASE_BITS  = 24;
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_BITS  = $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS   = PHASE_BITS - 2;

    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = SAMPLE_W + 1;
    localparam int LEVEL_W     = 16;
    localparam int PROD_W      = MAG_W + LEVEL_W;
    localparam int STEP_W      = 24;
    localparam int COUNT_W     = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_SAMPLES  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEREO        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_SAMPLES = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd32768;
    localparam logic [MAG_W-1:0]   FULL_SCALE  = 17'd32768;
    localparam logic [1:0]         COPIES_MONO   = 2'd1;
    localparam logic [1:0]         COPIES_STEREO = 2'd2;

    // Control flags that travel with a frame through the pipeline.
    typedef struct packed {
        logic neg;
        logic full;
        logic last;
    } frame_ctl_t;

    // Table fill sequencer to RAM write port and the top-level gate.
    typedef struct packed {
        logic                  wr_en;
        logic [TABLE_BITS-1:0] addr;
        logic [SAMPLE_W-1:0]   data;
        logic                  done;
    } fill_t;

    typedef logic [SAMPLE_W-1:0] sine_rom_t [TABLE_DEPTH];

    // Two multiplies of the Taylor recurrence, both in Q28.
    function automatic logic [63:0] taylor_step(logic [63:0] t, logic [63:0] x);
        logic [63:0] u;
        u = (t * x) >> 28;
        return (u * x) >> 28;
    endfunction

    // Quarter-wave entry k: sin((pi/2)*k/DEPTH) in Q1.15, rounded, clamped to 32767.
    function automatic logic [SAMPLE_W-1:0] sine_entry(int unsigned k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'd421657428 * 64'(k)) / 64'(TABLE_DEPTH);
        term = x;
        sum  = x;
        term = taylor_step(term, x) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = taylor_step(term, x) / 64'd20;
        sum  = sum + term;
        term = taylor_step(term, x) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = taylor_step(term, x) / 64'd72;
        sum  = sum + term;
        term = taylor_step(term, x) / 64'd110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = taylor_step(term, x) / 64'd156;
        sum  = sum + term;
        term = taylor_step(term, x) / 64'd210;
        sum  = (sum >= term) ? sum - term : 64'd0;
        r = (sum * 64'd32768 + (64'd1 << 27)) >> 28;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t t;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/stg_tick_if.sv =====
// Tick channel: valid/ready handshake carrying the restart flag.
// Depends on nothing.
`default_nettype none

interface stg_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/stg_frame_if.sv =====
// Frame channel: valid/ready handshake carrying one sample frame.
// Depends on nothing.
`default_nettype none

interface stg_frame_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_word;
    logic [1:0]  copies;
    logic        last;

    modport source (output valid, output sample_word, output copies, output last,
                    input ready);
    modport sink   (input valid, input sample_word, input copies, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/stg_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module stg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/stg_fill.sv =====
// Sweep that loads the quarter-wave table into the sine RAM after reset.
// Depends on stg_pkg.
`default_nettype none

module stg_fill
    import stg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    output fill_t     fill
);

    logic [TABLE_BITS:0] cnt_reg;
    logic [TABLE_BITS:0] cnt_next;
    logic                done;

    // The top bit of the counter sets once every entry has been written.
    assign done     = cnt_reg[TABLE_BITS];
    assign cnt_next = done ? cnt_reg : cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        fill.wr_en = !done;
        fill.addr  = cnt_reg[TABLE_BITS-1:0];
        fill.data  = SINE_ROM[cnt_reg[TABLE_BITS-1:0]];
        fill.done  = done;
    end

endmodule

`default_nettype wire

// ===== rtl/sine_tone_generator_unit.sv =====
// Sine tone generator top level: configuration registers, phase and frame counters,
// sine RAM read, level multiply and sample formatting. Depends on stg_pkg, the
// channel interfaces, stg_ram and stg_fill.
//
//   channel  | dir | word fields                      | notes
//   ---------+-----+----------------------------------+-----------------------------
//   tick     | in  | restart                          | one tick, zero or one frame
//   frame    | out | sample_word, copies, last        | registered output
//   cfg      | in  | cfg_wr_en, cfg_index, cfg_data   | write only, no wait
//
// One tick is accepted per cycle while the pipeline is not stalled; a frame passes
// through three registered stages (RAM read, multiply, format) on its way out.
// After reset a sweep loads all 256 sine RAM entries; ticks are not taken until it ends.
// Each stage holds its word while the next one is full, so a stall on the output
// reaches the tick side only once all three stages are occupied.
`default_nettype none

module sine_tone_generator_unit
    import stg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    stg_tick_if.sink                    tick,
    stg_frame_if.source                 frame,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [STEP_W-1:0]  phase_step_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               wide_reg;
    logic               stereo_reg;
    logic [COUNT_W-1:0] total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            level_reg      <= LEVEL_RESET;
            wide_reg       <= 1'b1;
            stereo_reg     <= 1'b0;
            total_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PHASE_STEP:    phase_step_reg <= cfg_data[STEP_W-1:0];
                CFG_LEVEL:         level_reg      <= cfg_data[LEVEL_W-1:0];
                CFG_WIDE_SAMPLES:  wide_reg       <= cfg_data[0];
                CFG_STEREO:        stereo_reg     <= cfg_data[0];
                CFG_TOTAL_SAMPLES: total_reg      <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Sine table memory and its fill sweep
    fill_t                 fill;
    logic                  ram_rd_en;
    logic [TABLE_BITS-1:0] ram_rd_addr;
    logic [SAMPLE_W-1:0]   ram_rd_data;

    stg_fill u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .fill  (fill)
    );

    stg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_sine_ram (
        .clk     (clk),
        .wr_en   (fill.wr_en),
        .wr_addr (fill.addr),
        .wr_data (fill.data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Pipeline occupancy and back-pressure
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic tick_fire;

    assign out_ready = !out_valid_reg || frame.ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign tick.ready = s1_ready && fill.done;
    assign tick_fire  = tick.valid && tick.ready;

    // Tick stage: restart, burst check, table address, counter update
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [COUNT_W-1:0]    frames_done_reg;
    logic [COUNT_W-1:0]    frames_done_next;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [COUNT_W-1:0]    frames_cur;
    logic [COUNT_W-1:0]    frames_inc;
    logic                  produce;
    logic [1:0]            quad;
    logic [TABLE_BITS-1:0] idx;
    frame_ctl_t            ctl_in;

    assign phase_cur  = tick.restart ? '0 : phase_acc_reg;
    assign frames_cur = tick.restart ? '0 : frames_done_reg;
    assign frames_inc = frames_cur + 1'b1;
    assign produce    = frames_cur < total_reg;
    assign quad       = phase_cur[PHASE_BITS-1 -: 2];

    // Phase bits below the quadrant address the table; short phases are zero padded.
    generate
        if (FRAC_BITS >= TABLE_BITS)
        begin : g_idx_drop
            assign idx = phase_cur[FRAC_BITS-1 -: TABLE_BITS];
        end
        else
        begin : g_idx_pad
            assign idx = {phase_cur[FRAC_BITS-1:0], {(TABLE_BITS - FRAC_BITS){1'b0}}};
        end
    endgenerate

    // Odd quadrants run the table backwards; their zero index is full scale.
    assign ram_rd_addr = quad[0] ? TABLE_BITS'(0) - idx : idx;
    assign ram_rd_en   = s1_ready;

    always_comb
    begin
        ctl_in.neg  = quad[1];
        ctl_in.full = quad[0] && (idx == '0);
        ctl_in.last = frames_inc == total_reg;
    end

    always_comb
    begin
        phase_acc_next   = phase_acc_reg;
        frames_done_next = frames_done_reg;
        if (tick_fire)
        begin
            phase_acc_next   = phase_cur;
            frames_done_next = frames_cur;
            if (produce)
            begin
                phase_acc_next   = phase_cur + PHASE_BITS'(phase_step_reg);
                frames_done_next = frames_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg   <= '0;
            frames_done_reg <= '0;
        end
        else
        begin
            phase_acc_reg   <= phase_acc_next;
            frames_done_reg <= frames_done_next;
        end
    end

    // Stage 1: table word arrives from the RAM
    frame_ctl_t s1_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= tick_fire && produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_ctl_reg <= ctl_in;
        end
    end

    // Stage 2: magnitude times level
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod_reg;
    frame_ctl_t        s2_ctl_reg;

    assign mag = s1_ctl_reg.full ? FULL_SCALE : {1'b0, ram_rd_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            prod_reg   <= PROD_W'(mag) * PROD_W'(level_reg);
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // Stage 3: format and saturate into the output register
    logic [MAG_W-1:0]    wide_mag;
    logic [PROD_W:0]     narrow_round;
    logic [11:0]         narrow_neg_mag;
    logic [11:0]         narrow_pos;
    logic [SAMPLE_W-1:0] word;

    assign wide_mag       = prod_reg[15 +: MAG_W];
    assign narrow_round   = {1'b0, prod_reg} + (PROD_W + 1)'((1 << 22) - 1);
    assign narrow_neg_mag = narrow_round[22 +: 12];
    assign narrow_pos     = 12'd128 + 12'(prod_reg[PROD_W-1:22]);

    always_comb
    begin
        if (wide_reg)
        begin
            if (s2_ctl_reg.neg)
            begin
                word = (wide_mag >= FULL_SCALE) ? 16'h8000 : SAMPLE_W'(~wide_mag + 1'b1);
            end
            else
            begin
                word = (wide_mag > 17'd32767) ? 16'h7fff : wide_mag[SAMPLE_W-1:0];
            end
        end
        else
        begin
            if (s2_ctl_reg.neg)
            begin
                word = (narrow_neg_mag >= 12'd128) ? 16'd0
                                                   : SAMPLE_W'(12'd128 - narrow_neg_mag);
            end
            else
            begin
                word = (narrow_pos > 12'd255) ? 16'd255 : SAMPLE_W'(narrow_pos);
            end
        end
    end

    logic [SAMPLE_W-1:0] word_reg;
    logic [1:0]          copies_reg;
    logic                last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            word_reg   <= word;
            copies_reg <= stereo_reg ? COPIES_STEREO : COPIES_MONO;
            last_reg   <= s2_ctl_reg.last;
        end
    end

    assign frame.valid       = out_valid_reg;
    assign frame.sample_word = word_reg;
    assign frame.copies      = copies_reg;
    assign frame.last        = last_reg;

endmodule

`default_nettype wire

// ===== rtl/stg_checker.sv =====
// Port-level checks for the sine tone generator, bound to the top level.
// Depends on stg_pkg and sine_tone_generator_unit.
`default_nettype none

module stg_checker
    import stg_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [15:0]            sample_word,
    input wire logic [1:0]             copies,
    input wire logic                   last,
    input wire logic                   cfg_wr_en,
    input wire logic [CFG_INDEX_W-1:0] cfg_index,
    input wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Copies of the mode registers as seen from the write port.
    logic wide_reg;
    logic stereo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg   <= 1'b1;
            stereo_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_WIDE_SAMPLES)
            begin
                wide_reg <= cfg_data[0];
            end
            if (cfg_index == CFG_STEREO)
            begin
                stereo_reg <= cfg_data[0];
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_word)
                                    && $stable(copies) && $stable(last))
        else $error("output word changed while stalled");

    a_fill_gate: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready ##1 !in_ready)
        else $error("tick taken before the sine table was loaded");

    a_copies: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stereo_reg ? copies == COPIES_STEREO : copies == COPIES_MONO))
        else $error("copies does not follow the stereo setting");

    a_narrow_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !wide_reg |-> sample_word[15:8] == 8'd0)
        else $error("8-bit sample has a nonzero high byte");

endmodule

bind sine_tone_generator_unit stg_checker u_stg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (tick.ready),
    .out_valid   (frame.valid),
    .out_ready   (frame.ready),
    .sample_word (frame.sample_word),
    .copies      (frame.copies),
    .last        (frame.last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for sine_tone_generator_unit: a directed table, then random
// bursts under random tick and frame stalls, each frame checked against a built-in tone model.
// Depends on stg_pkg, stg_tick_if, stg_frame_if and the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stg_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 10;
    localparam int STAGE_TICKS = 110;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [15:0] word;
        logic [1:0]  copies;
        logic        last;
    } tone_frame_t;

    typedef enum logic [1:0] {ROW_TICK, ROW_WRITE} row_kind_e;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FRAME} row_check_e;

    typedef struct packed {
        row_kind_e              kind;
        logic                   restart;
        row_check_e             check;
        tone_frame_t            frame;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    stg_tick_if  tick_ch ();
    stg_frame_if frame_ch ();

    sine_tone_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .frame     (frame_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Tone model: configuration copy, phase and frame count, quarter-wave table.
    logic [23:0]          step_reg   = '0;
    logic [LEVEL_W-1:0]   level_reg  = LEVEL_RESET;
    logic                 wide_reg   = 1'b1;
    logic                 stereo_reg = 1'b0;
    logic [31:0]          burst_len  = '0;
    logic [PHASE_BITS-1:0] tone_phase = '0;
    logic [31:0]          frames_sent = '0;
    logic [15:0]          quarter_sine [TABLE_DEPTH];

    tone_frame_t pending_frames [$];
    stim_row_t   tick_row_now;
    stim_row_t   directed [$];
    int unsigned ticks_taken = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;

    initial
    begin : sine_fill
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            x    = (64'd421657428 * 64'(k)) / 64'(TABLE_DEPTH);
            term = x;
            sum  = x;
            for (int n = 1; n <= 7; n++)
            begin
                term = (term * x) >> 28;
                term = ((term * x) >> 28) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            r = (sum * 64'd32768 + (64'd1 << 27)) >> 28;
            quarter_sine[k] = (r > 64'd32767) ? 16'd32767 : r[15:0];
        end
    end

    // Advances the tone model by one tick; returns 1 when the tick yields a frame.
    function automatic bit advance_tone(input logic restart, output tone_frame_t f);
        logic [1:0]  quad;
        logic [TABLE_BITS-1:0] idx;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] m;
        logic        neg;
        f = '0;
        if (restart)
        begin
            tone_phase  = '0;
            frames_sent = '0;
        end
        if (frames_sent >= burst_len)
        begin
            return 1'b0;
        end
        quad = tone_phase[PHASE_BITS-1 -: 2];
        idx  = tone_phase[FRAC_BITS-1 -: TABLE_BITS];
        neg  = quad[1];
        if (quad[0])
        begin
            mag = (idx == 0) ? 64'(FULL_SCALE) : 64'(quarter_sine[TABLE_DEPTH - int'(idx)]);
        end
        else
        begin
            mag = 64'(quarter_sine[idx]);
        end
        prod = mag * 64'(level_reg);
        if (wide_reg)
        begin
            m = prod >> 15;
            if (neg)
            begin
                if (m > 64'd32768)
                begin
                    m = 64'd32768;
                end
                m = (64'd65536 - m) & 64'hFFFF;
            end
            else if (m > 64'd32767)
            begin
                m = 64'd32767;
            end
        end
        else if (neg)
        begin
            m = (prod + 64'd4194303) >> 22;
            m = (m >= 64'd128) ? 64'd0 : 64'd128 - m;
        end
        else
        begin
            m = 64'd128 + (prod >> 22);
            if (m > 64'd255)
            begin
                m = 64'd255;
            end
        end
        tone_phase  = tone_phase + step_reg;
        frames_sent = frames_sent + 32'd1;
        f.word   = m[15:0];
        f.copies = stereo_reg ? COPIES_STEREO : COPIES_MONO;
        f.last   = (frames_sent == burst_len);
        return 1'b1;
    endfunction

    function automatic stim_row_t tick_row(logic restart, row_check_e check,
                                           logic [15:0] word, logic [1:0] copies,
                                           logic last);
        stim_row_t r;
        r = '0;
        r.kind    = ROW_TICK;
        r.restart = restart;
        r.check   = check;
        r.frame   = '{word, copies, last};
        return r;
    endfunction

    function automatic stim_row_t write_row(logic [CFG_INDEX_W-1:0] index,
                                            logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r = '0;
        r.kind  = ROW_WRITE;
        r.index = index;
        r.data  = data;
        return r;
    endfunction

    task automatic report_mismatch(string what, tone_frame_t want, tone_frame_t got);
        if (mismatches < 10)
        begin
            $display("%0t %s: expected word %h copies %0d last %0d, got word %h copies %0d last %0d",
                     $realtime, what, want.word, want.copies, want.last,
                     got.word, got.copies, got.last);
        end
        mismatches++;
    endtask

    // All sampling happens here, at the rising edge; drivers only act on the falling edge.
    always @(posedge clk)
    begin : monitor
        tone_frame_t got;
        tone_frame_t want;
        tone_frame_t predicted;
        bit          made;
        if (rst_n)
        begin
            idle_cycles++;
            if (frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
            begin
                idle_cycles = 0;
                got = '{frame_ch.sample_word, frame_ch.copies, frame_ch.last};
                if (pending_frames.size() == 0)
                begin
                    report_mismatch("unexpected word", '0, got);
                end
                else
                begin
                    want = pending_frames.pop_front();
                    if (got.word !== want.word || got.copies !== want.copies
                        || got.last !== want.last)
                    begin
                        report_mismatch("word mismatch", want, got);
                    end
                end
            end
            if (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1)
            begin
                idle_cycles = 0;
                ticks_taken++;
                made = advance_tone(tick_ch.restart, predicted);
                if (tick_row_now.check == CHK_FRAME)
                begin
                    pending_frames.push_back(tick_row_now.frame);
                end
                else if (tick_row_now.check == CHK_MODEL && made)
                begin
                    pending_frames.push_back(predicted);
                end
            end
            if (cfg_wr_en)
            begin
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        frame_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_tick(input stim_row_t row);
        int unsigned seen;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            tick_ch.valid = 1'b0;
            @(negedge clk);
        end
        tick_ch.valid   = 1'b1;
        tick_ch.restart = row.restart;
        tick_row_now    = row;
        seen = ticks_taken;
        @(negedge clk);
        while (ticks_taken == seen)
        begin
            @(negedge clk);
        end
    endtask

    // Holds ticks back until every expected word is out and the pipeline has emptied.
    task automatic wait_idle();
        tick_ch.valid = 1'b0;
        while (pending_frames.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        case (index)
            CFG_PHASE_STEP:    step_reg   = data[23:0];
            CFG_LEVEL:         level_reg  = data[LEVEL_W-1:0];
            CFG_WIDE_SAMPLES:  wide_reg   = data[0];
            CFG_STEREO:        stereo_reg = data[0];
            CFG_TOTAL_SAMPLES: burst_len  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    initial
    begin : driver
        bit          flowing;
        int unsigned goal;
        int unsigned burst;
        logic [31:0] junk;
        logic [31:0] value;
        tick_ch.valid   = 1'b0;
        tick_ch.restart = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_PHASE_STEP;
        cfg_data        = '0;
        tick_row_now    = '0;
        flowing         = 1'b0;

        // A quarter-cycle step walks the four quadrant boundaries: zero, full scale,
        // zero, negative full scale, which exercises every saturation corner.
        directed = '{
            tick_row(1'b0, CHK_NONE, 16'h0000, COPIES_MONO, 1'b0),
            tick_row(1'b1, CHK_NONE, 16'h0000, COPIES_MONO, 1'b0),
            write_row(CFG_PHASE_STEP, 32'h0040_0000),
            write_row(CFG_TOTAL_SAMPLES, 32'd6),
            tick_row(1'b0, CHK_FRAME, 16'h0000, COPIES_MONO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h7FFF, COPIES_MONO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h0000, COPIES_MONO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h8000, COPIES_MONO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h0000, COPIES_MONO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h7FFF, COPIES_MONO, 1'b1),
            tick_row(1'b0, CHK_NONE, 16'h0000, COPIES_MONO, 1'b0),
            tick_row(1'b1, CHK_FRAME, 16'h0000, COPIES_MONO, 1'b0),
            write_row(CFG_WIDE_SAMPLES, 32'd0),
            write_row(CFG_STEREO, 32'd1),
            tick_row(1'b1, CHK_FRAME, 16'h0080, COPIES_STEREO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h00FF, COPIES_STEREO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h0080, COPIES_STEREO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h0000, COPIES_STEREO, 1'b0),
            write_row(CFG_LEVEL, 32'h0000_FFFF),
            write_row(CFG_WIDE_SAMPLES, 32'd1),
            tick_row(1'b1, CHK_FRAME, 16'h0000, COPIES_STEREO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h7FFF, COPIES_STEREO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h0000, COPIES_STEREO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h8000, COPIES_STEREO, 1'b0),
            write_row(CFG_LEVEL, 32'd0),
            write_row(CFG_UNUSED, 32'hFFFF_FFFF),
            tick_row(1'b1, CHK_FRAME, 16'h0000, COPIES_STEREO, 1'b0),
            tick_row(1'b0, CHK_FRAME, 16'h0000, COPIES_STEREO, 1'b0),
            write_row(CFG_PHASE_STEP, 32'h0012_3457),
            write_row(CFG_LEVEL, 32'h0000_5A5A),
            write_row(CFG_TOTAL_SAMPLES, 32'hFFFF_FFFF),
            tick_row(1'b1, CHK_MODEL, 16'h0000, COPIES_STEREO, 1'b0),
            tick_row(1'b0, CHK_MODEL, 16'h0000, COPIES_STEREO, 1'b0),
            tick_row(1'b0, CHK_MODEL, 16'h0000, COPIES_STEREO, 1'b0),
            write_row(CFG_WIDE_SAMPLES, 32'd0),
            tick_row(1'b0, CHK_MODEL, 16'h0000, COPIES_STEREO, 1'b0),
            tick_row(1'b0, CHK_MODEL, 16'h0000, COPIES_STEREO, 1'b0),
            write_row(CFG_TOTAL_SAMPLES, 32'd1),
            tick_row(1'b1, CHK_FRAME, 16'h0080, COPIES_STEREO, 1'b1),
            tick_row(1'b0, CHK_NONE, 16'h0000, COPIES_STEREO, 1'b0)
        };

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[n])
        begin
            if (directed[n].kind == ROW_WRITE)
            begin
                if (flowing)
                begin
                    wait_idle();
                    flowing = 1'b0;
                end
                write_reg(directed[n].index, directed[n].data);
            end
            else
            begin
                send_tick(directed[n]);
                flowing = 1'b1;
            end
        end

        for (int stage = 0; stage < 3; stage++)
        begin
            case (stage)
                0:       begin tx_idle_pct = 20; rx_idle_pct = 82; end
                1:       begin tx_idle_pct = 82; rx_idle_pct = 20; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            goal = ticks_taken + STAGE_TICKS;
            while (ticks_taken < goal)
            begin
                wait_idle();
                // New burst setup; junk in the unused upper data bits must be ignored.
                if ($urandom_range(9) < 6)
                begin
                    junk = $urandom;
                    case ($urandom_range(4))
                        0:       value = 32'd0;
                        1:       value = 32'h00FF_FFFF;
                        2:       value = 32'h0040_0000;
                        3:       value = 32'h0080_0000;
                        default: value = 32'($urandom_range(32'h00FF_FFFF));
                    endcase
                    write_reg(CFG_PHASE_STEP, {junk[31:24], value[23:0]});
                end
                if ($urandom_range(9) < 6)
                begin
                    junk = $urandom;
                    case ($urandom_range(4))
                        0:       value = 32'd0;
                        1:       value = 32'd32768;
                        2:       value = 32'd65535;
                        3:       value = 32'd1;
                        default: value = 32'($urandom_range(65535));
                    endcase
                    write_reg(CFG_LEVEL, {junk[31:16], value[15:0]});
                end
                if ($urandom_range(9) < 6)
                begin
                    junk = $urandom;
                    write_reg(CFG_WIDE_SAMPLES, {junk[31:1], 1'($urandom_range(1))});
                end
                if ($urandom_range(9) < 6)
                begin
                    junk = $urandom;
                    write_reg(CFG_STEREO, {junk[31:1], 1'($urandom_range(1))});
                end
                if ($urandom_range(9) < 6)
                begin
                    case ($urandom_range(9))
                        0:       value = 32'd0;
                        1:       value = 32'd1;
                        2:       value = 32'hFFFF_FFFF;
                        3:       value = $urandom;
                        default: value = 32'($urandom_range(40, 2));
                    endcase
                    write_reg(CFG_TOTAL_SAMPLES, value);
                end
                if ($urandom_range(19) == 0)
                begin
                    write_reg(3'($urandom_range(7, 5)), $urandom);
                end
                burst = $urandom_range(40, 4);
                for (int i = 0; i < burst; i++)
                begin
                    if ($urandom_range(49) == 0)
                    begin
                        wait_idle();
                    end
                    send_tick(tick_row(i == 0 ? ($urandom_range(4) != 0)
                                              : ($urandom_range(15) == 0),
                                       CHK_MODEL, 16'h0000, COPIES_MONO, 1'b0));
                end
            end
        end

        wait_idle();
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stg_pkg.sv
rtl/stg_tick_if.sv
rtl/stg_frame_if.sv
rtl/stg_ram.sv
rtl/stg_fill.sv
rtl/sine_tone_generator_unit.sv
rtl/stg_checker.sv
tb/sv/tb_top.sv
